// ----- rtl/cprb_pkg.sv -----
// Shared types, constants and a saturation helper for the rotated-box
// closest-point core. No dependencies.
`default_nettype none
package cprb_pkg;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [31:0] box_center_x;
        logic signed [31:0] box_center_y;
        logic signed [31:0] box_center_z;
        logic [30:0]        half_extent_x;
        logic [30:0]        half_extent_y;
        logic [30:0]        half_extent_z;
        logic [63:0]        box_rotation;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] near_x;
        logic signed [31:0] near_y;
        logic signed [31:0] near_z;
    } t_out_word;

    typedef logic signed [31:0] t_coord;
    typedef logic signed [15:0] t_qpart;

    localparam int QDEPTH = 4;
    localparam int QAW = $clog2(QDEPTH);

    // saturate a 64-bit signed value to the coordinate range
    function automatic t_coord sat32(input logic signed [63:0] x);
        logic signed [63:0] mx;
        logic signed [63:0] mn;
        begin
            mx = 64'sh0000_0000_7FFF_FFFF;
            mn = -64'sh0000_0000_8000_0000;
            if (x > mx) sat32 = 32'sh7FFF_FFFF;
            else if (x < mn) sat32 = 32'sh8000_0000;
            else sat32 = x[31:0];
        end
    endfunction

endpackage
`default_nettype wire

// ----- rtl/cprb_front.sv -----
// Front end: accepts a word and pushes it into the queue; busy follows queue full.
// Depends on cprb_pkg.
`default_nettype none
module cprb_front import cprb_pkg::*; (
    input  wire logic     i_start,
    input  wire t_in_word i_word,
    input  wire logic     i_full,
    output logic          o_busy,
    output logic          o_push,
    output t_in_word      o_word
);
    // no per-item iteration: each word goes straight to the queue
    always_comb begin
        o_busy = i_full;
        o_push = i_start && !i_full;
        o_word = i_word;
    end
endmodule
`default_nettype wire

// ----- rtl/cprb_queue.sv -----
// Short FIFO between front and back end. Depends on cprb_pkg.
`default_nettype none
module cprb_queue import cprb_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_in_word i_word,
    input  wire logic     i_pop,
    output logic          o_full,
    output logic          o_empty,
    output t_in_word      o_word
);
    t_in_word r_mem [QDEPTH];
    logic [QAW:0] r_wp, r_rp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp[QAW-1:0]] <= i_word;
    end
    always_comb begin
        o_empty = (r_wp == r_rp);
        o_full  = (r_wp[QAW-1:0] == r_rp[QAW-1:0]) && (r_wp[QAW] != r_rp[QAW]);
        o_word  = r_mem[r_rp[QAW-1:0]];
    end
endmodule
`default_nettype wire

// ----- rtl/cprb_back.sv -----
// Back end: pipelined rotation of eight corners, bounds and clamp.
// Depends on cprb_pkg.
`default_nettype none
module cprb_back import cprb_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_in_word i_word,
    output logic          o_valid,
    output t_out_word     o_word
);
    localparam int NS = 7;

    // stage 0: latch inputs, build the eight corner vectors
    logic [NS-1:0] r_v;
    t_coord r_p0 [3], r_c0 [3];
    logic signed [31:0] r_e [3];
    logic signed [15:0] r_u [3];
    logic signed [15:0] r_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else r_v <= {r_v[NS-2:0], i_valid};
    end

    always_ff @(posedge i_clk) begin
        r_p0[0] <= i_word.point_x;
        r_p0[1] <= i_word.point_y;
        r_p0[2] <= i_word.point_z;
        r_c0[0] <= i_word.box_center_x;
        r_c0[1] <= i_word.box_center_y;
        r_c0[2] <= i_word.box_center_z;
        r_e[0] <= {1'b0, i_word.half_extent_x};
        r_e[1] <= {1'b0, i_word.half_extent_y};
        r_e[2] <= {1'b0, i_word.half_extent_z};
        r_u[0] <= i_word.box_rotation[15:0];
        r_u[1] <= i_word.box_rotation[31:16];
        r_u[2] <= i_word.box_rotation[47:32];
        r_w    <= i_word.box_rotation[63:48];
    end

    // corner k: bit0 -> z sign, bit1 -> y, bit2 -> x (1 = plus)
    logic signed [31:0] v_c [8][3];
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            v_c[k][0] = k[2] ? r_e[0] : -r_e[0];
            v_c[k][1] = k[1] ? r_e[1] : -r_e[1];
            v_c[k][2] = k[0] ? r_e[2] : -r_e[2];
        end
    end

    // stage 1: products u x v
    logic signed [47:0] r_m1 [8][6];
    logic signed [31:0] r_v1 [8][3];
    t_coord r_p1 [3], r_c1 [3];
    logic signed [15:0] r_u1 [3], r_w1;
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 8; k++) begin
            r_m1[k][0] <= r_u[1] * v_c[k][2];
            r_m1[k][1] <= r_u[2] * v_c[k][1];
            r_m1[k][2] <= r_u[2] * v_c[k][0];
            r_m1[k][3] <= r_u[0] * v_c[k][2];
            r_m1[k][4] <= r_u[0] * v_c[k][1];
            r_m1[k][5] <= r_u[1] * v_c[k][0];
            for (int d = 0; d < 3; d++) r_v1[k][d] <= v_c[k][d];
        end
        r_p1 <= r_p0; r_c1 <= r_c0; r_u1 <= r_u; r_w1 <= r_w;
    end

    // stage 2: t = sat(round(c,14))
    t_coord r_t2 [8][3];
    logic signed [31:0] r_v2 [8][3];
    t_coord r_p2 [3], r_c2 [3];
    logic signed [15:0] r_u2 [3], r_w2;
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 8; k++) begin
            for (int d = 0; d < 3; d++) begin
                logic signed [63:0] cx;
                cx = 64'(r_m1[k][2*d]) - 64'(r_m1[k][2*d+1]) + 64'sd8192;
                r_t2[k][d] <= sat32(cx >>> 14);
            end
            r_v2[k] <= r_v1[k];
        end
        r_p2 <= r_p1; r_c2 <= r_c1; r_u2 <= r_u1; r_w2 <= r_w1;
    end

    // stage 3: products w*t and u x t
    logic signed [47:0] r_m3 [8][6];
    logic signed [47:0] r_a3 [8][3];
    logic signed [31:0] r_v3 [8][3];
    t_coord r_p3 [3], r_c3 [3];
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 8; k++) begin
            r_m3[k][0] <= r_u2[1] * r_t2[k][2];
            r_m3[k][1] <= r_u2[2] * r_t2[k][1];
            r_m3[k][2] <= r_u2[2] * r_t2[k][0];
            r_m3[k][3] <= r_u2[0] * r_t2[k][2];
            r_m3[k][4] <= r_u2[0] * r_t2[k][1];
            r_m3[k][5] <= r_u2[1] * r_t2[k][0];
            for (int d = 0; d < 3; d++) r_a3[k][d] <= r_w2 * r_t2[k][d];
            r_v3[k] <= r_v2[k];
        end
        r_p3 <= r_p2; r_c3 <= r_c2;
    end

    // stage 4: r = sat(v+a+b), corner = sat(c+r)
    t_coord r_q4 [8][3];
    t_coord r_p4 [3], r_c4 [3];
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 8; k++) begin
            for (int d = 0; d < 3; d++) begin
                logic signed [63:0] av, bv, rv;
                t_coord a, b, r;
                av = 64'(r_a3[k][d]) + 64'sd4096;
                bv = 64'(r_m3[k][2*d]) - 64'(r_m3[k][2*d+1]) + 64'sd4096;
                a = sat32(av >>> 13);
                b = sat32(bv >>> 13);
                rv = 64'(r_v3[k][d]) + 64'(a) + 64'(b);
                r = sat32(rv);
                r_q4[k][d] <= sat32(64'(r_c3[d]) + 64'(r));
            end
        end
        r_p4 <= r_p3; r_c4 <= r_c3;
    end

    // stage 5: min/max tree over corners, then the center
    t_coord r_lo5 [3], r_hi5 [3], r_p5 [3];
    always_ff @(posedge i_clk) begin
        t_coord l1 [4], h1 [4], l2 [2], h2 [2], l3, h3;
        for (int d = 0; d < 3; d++) begin
            for (int j = 0; j < 4; j++) begin
                l1[j] = (r_q4[2*j][d] < r_q4[2*j+1][d]) ? r_q4[2*j][d] : r_q4[2*j+1][d];
                h1[j] = (r_q4[2*j][d] > r_q4[2*j+1][d]) ? r_q4[2*j][d] : r_q4[2*j+1][d];
            end
            for (int j = 0; j < 2; j++) begin
                l2[j] = (l1[2*j] < l1[2*j+1]) ? l1[2*j] : l1[2*j+1];
                h2[j] = (h1[2*j] > h1[2*j+1]) ? h1[2*j] : h1[2*j+1];
            end
            l3 = (l2[0] < l2[1]) ? l2[0] : l2[1];
            h3 = (h2[0] > h2[1]) ? h2[0] : h2[1];
            r_lo5[d] <= (l3 < r_c4[d]) ? l3 : r_c4[d];
            r_hi5[d] <= (h3 > r_c4[d]) ? h3 : r_c4[d];
        end
        r_p5 <= r_p4;
    end

    // stage 6: clamp
    always_ff @(posedge i_clk) begin
        t_coord q [3];
        for (int d = 0; d < 3; d++) begin
            q[d] = r_p5[d];
            if (q[d] < r_lo5[d]) q[d] = r_lo5[d];
            if (q[d] > r_hi5[d]) q[d] = r_hi5[d];
        end
        o_word.near_x <= q[0];
        o_word.near_y <= q[1];
        o_word.near_z <= q[2];
    end

    assign o_valid = r_v[NS-1];
endmodule
`default_nettype wire

// ----- rtl/closest_point_on_rotated_box_core.sv -----
// Closest point on the axis-aligned bounds of a rotated box: top level.
// A start reaches o_done through the queue and the seven back-end stages.
// Throughput: one word per cycle; the back end never stalls, queue holds at most one word.
// busy rises only if the queue fills; the receiver cannot stall results.
// Reset (synchronous, active low) empties the queue and pipeline valids.
`default_nettype none
module closest_point_on_rotated_box_core import cprb_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      start,
    input  wire t_in_word  i_word,
    output logic           busy,
    output logic           o_done,
    output t_out_word      o_word
);
    logic     push, full, empty;
    t_in_word fw, qw;

    cprb_front u_front (
        .i_start(start), .i_word(i_word),
        .i_full(full), .o_busy(busy), .o_push(push), .o_word(fw)
    );

    // back end takes a word each cycle the queue is not empty
    cprb_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_word(fw),
        .i_pop(!empty), .o_full(full), .o_empty(empty), .o_word(qw)
    );

    cprb_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(!empty), .i_word(qw),
        .o_valid(o_done), .o_word(o_word)
    );

`ifndef SYNTHESIS
    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("queue filled");
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##8 (o_done || !i_rst_n))
        else $error("missing result");
    a_empty_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (empty && !push) |=> empty)
        else $error("queue gained word");
`endif
endmodule
`default_nettype wire

// ----- sim/tb_closest_point_on_rotated_box_core.sv -----
// Testbench for closest_point_on_rotated_box_core: directed table plus random words,
// checked against typed answers or an in-bench predictor of the rotated-box clamp. Depends on cprb_pkg.
`default_nettype none
module tb_closest_point_on_rotated_box_core;
    timeunit 1ns;
    timeprecision 1ps;
    import cprb_pkg::*;

    localparam int LATENCY     = 8;
    localparam int N_RANDOM    = 1400;
    localparam int CYCLE_LIMIT = 400000;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    t_in_word  i_word;
    logic      busy;
    logic      o_done;
    t_out_word o_word;

    closest_point_on_rotated_box_core DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_word (i_word),
        .busy   (busy),
        .o_done (o_done),
        .o_word (o_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Expected near points, oldest first
    t_out_word near_q[$];
    int        n_errors;
    int        cycle_cnt;

    // Directed rows; has_exp marks rows whose answer is typed in
    typedef struct {
        t_in_word  w;
        bit        has_exp;
        t_out_word e;
    } t_row;
    t_row rows[$];

    function automatic void add_row(t_in_word w, bit has_exp, t_out_word e);
        t_row r;
        r.w       = w;
        r.has_exp = has_exp;
        r.e       = e;
        rows.insert(rows.size(), r);
    endfunction

    // ---------------- predictor ----------------
    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // add 2^(s-1), then arithmetic (floor) shift
    function automatic longint rnd_shift(longint x, int s);
        longint y;
        y = x + (64'sd1 <<< (s - 1));
        return y >>> s;
    endfunction

    function automatic void cross3(input longint a[3], input longint b[3],
                                   output longint c[3]);
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic t_out_word predict_near(t_in_word w);
        longint p[3], c[3], e[3], u[3], qw, lo[3], hi[3];
        longint v[3], cr[3], t[3], r[3], a, b, q;
        t_out_word res;
        p[0] = longint'(w.point_x);
        p[1] = longint'(w.point_y);
        p[2] = longint'(w.point_z);
        c[0] = longint'(w.box_center_x);
        c[1] = longint'(w.box_center_y);
        c[2] = longint'(w.box_center_z);
        e[0] = longint'({33'b0, w.half_extent_x});
        e[1] = longint'({33'b0, w.half_extent_y});
        e[2] = longint'({33'b0, w.half_extent_z});
        u[0] = longint'(t_qpart'(w.box_rotation[15:0]));
        u[1] = longint'(t_qpart'(w.box_rotation[31:16]));
        u[2] = longint'(t_qpart'(w.box_rotation[47:32]));
        qw   = longint'(t_qpart'(w.box_rotation[63:48]));
        for (int d = 0; d < 3; d++) begin
            lo[d] = c[d];
            hi[d] = c[d];
        end
        for (int k = 0; k < 8; k++) begin
            v[0] = k[2] ? -e[0] : e[0];
            v[1] = k[1] ? -e[1] : e[1];
            v[2] = k[0] ? -e[2] : e[2];
            cross3(u, v, cr);
            for (int d = 0; d < 3; d++) t[d] = clamp32(rnd_shift(cr[d], 14));
            cross3(u, t, cr);
            for (int d = 0; d < 3; d++) begin
                a = clamp32(rnd_shift(qw * t[d], 13));
                b = clamp32(rnd_shift(cr[d], 13));
                r[d] = clamp32(v[d] + a + b);
                q = clamp32(c[d] + r[d]);
                if (q < lo[d]) lo[d] = q;
                if (q > hi[d]) hi[d] = q;
            end
        end
        for (int d = 0; d < 3; d++) begin
            if (p[d] < lo[d]) p[d] = lo[d];
            if (p[d] > hi[d]) p[d] = hi[d];
        end
        res.near_x = p[0][31:0];
        res.near_y = p[1][31:0];
        res.near_z = p[2][31:0];
        return res;
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic t_in_word make_word(int px, int py, int pz, int cx, int cy, int cz,
                                           int hx, int hy, int hz, logic [63:0] rot);
        t_in_word w;
        w.point_x = px; w.point_y = py; w.point_z = pz;
        w.box_center_x = cx; w.box_center_y = cy; w.box_center_z = cz;
        w.half_extent_x = hx[30:0]; w.half_extent_y = hy[30:0]; w.half_extent_z = hz[30:0];
        w.box_rotation = rot;
        return w;
    endfunction

    function automatic t_out_word make_near(int x, int y, int z);
        t_out_word o;
        o.near_x = x; o.near_y = y; o.near_z = z;
        return o;
    endfunction

    function automatic logic [63:0] rand_rot();
        logic [63:0] r;
        case ($urandom_range(0, 3))
            0: r = {$urandom, $urandom};                 // anything, non-unit
            1: r = {16'h4000, 48'h0};                    // identity
            2: r = {16'h2D41, 16'h0, 16'h0, 16'h2D41};   // 90 deg about x
            default: begin
                // small random parts around unit length
                r[15:0]  = 16'($signed($urandom_range(0, 16384)) - 8192);
                r[31:16] = 16'($signed($urandom_range(0, 16384)) - 8192);
                r[47:32] = 16'($signed($urandom_range(0, 16384)) - 8192);
                r[63:48] = 16'($urandom_range(8192, 16384));
            end
        endcase
        return r;
    endfunction

    function automatic int rand_coord(bit wide);
        if (wide || $urandom_range(0, 9) == 0) return int'($urandom);
        return int'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000;
    endfunction

    function automatic int rand_ext(bit wide);
        if (wide || $urandom_range(0, 9) == 0) return int'($urandom & 32'h7FFF_FFFF);
        return int'($urandom_range(0, 32'h0040_0000));
    endfunction

    function automatic t_in_word rand_word();
        bit wide;
        wide = ($urandom_range(0, 7) == 0);
        // points near the box most of the time so clamps go both ways
        return make_word(rand_coord(wide), rand_coord(wide), rand_coord(wide),
                         rand_coord(wide), rand_coord(wide), rand_coord(wide),
                         rand_ext(wide), rand_ext(wide), rand_ext(wide), rand_rot());
    endfunction

    function automatic void report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        n_errors++;
    endfunction

    // ---------------- driver ----------------
    // start stays high after acceptance so the next word can follow directly
    task automatic send_word(t_in_word w, bit typed, t_out_word e);
        int gap;
        // random idle before the word, mostly short
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start  <= 1'b1;
        i_word <= w;
        near_q.insert(near_q.size(), typed ? e : predict_near(w));
        // accepted at the rising edge where busy is low
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
    endtask

    task automatic idle_input();
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    // ---------------- checker ----------------
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_done) begin
            if (near_q.size() == 0) begin
                report_mismatch("unexpected result", o_word.near_x, 0);
            end else begin
                want = near_q.pop_front();
                if (o_word.near_x !== want.near_x)
                    report_mismatch("near_x", o_word.near_x, want.near_x);
                if (o_word.near_y !== want.near_y)
                    report_mismatch("near_y", o_word.near_y, want.near_y);
                if (o_word.near_z !== want.near_z)
                    report_mismatch("near_z", o_word.near_z, want.near_z);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ---------------- main sequence ----------------
    initial begin
        t_out_word none;
        localparam logic [63:0] ID = {16'h4000, 48'h0};
        localparam int MX = 32'h7FFF_FFFF;
        localparam int MN = 32'h8000_0000;
        localparam int HX = 32'h7FFF_FFFF;
        n_errors  = 0;
        cycle_cnt = 0;
        none      = '0;
        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_word    = '0;

        // all zero: degenerate box at origin
        add_row(make_word(0, 0, 0, 0, 0, 0, 0, 0, 0, 64'h0), 1, make_near(0, 0, 0));
        // zero extents, identity: point snaps to the center
        add_row(make_word(MX, MN, 5, 100, -100, 7, 0, 0, 0, ID), 1,
                make_near(100, -100, 7));
        // point inside passes through
        add_row(make_word(10, -20, 30, 0, 0, 0, 1000, 1000, 1000, ID), 1,
                make_near(10, -20, 30));
        // identity box, point outside on every axis
        add_row(make_word(MX, MN, MX, 0, 0, 0, 65536, 131072, 196608, ID), 1,
                make_near(65536, -131072, 196608));
        // saturation: max center plus max extent
        add_row(make_word(MX, MX, MX, MX, MX, MX, HX, HX, HX, ID), 1,
                make_near(MX, MX, MX));
        add_row(make_word(MN, MN, MN, MN, MN, MN, HX, HX, HX, ID), 1,
                make_near(MN, MN, MN));
        // full range box covers everything but MN, which clamps to MN + 1
        add_row(make_word(MX, MN, 0, 0, 0, 0, HX, HX, HX, ID), 1,
                make_near(MX, MN + 1, 0));
        // zero quaternion: corners collapse to center plus raw extents
        add_row(make_word(MX, MX, MX, 0, 0, 0, 50, 60, 70, 64'h0), 1,
                make_near(50, 60, 70));
        // assorted unit, non-unit and extreme quaternions, predictor only
        add_row(make_word(MX, MN, MX, 0, 0, 0, HX, HX, HX, 64'h8000_8000_8000_8000),
                0, none);
        add_row(make_word(MN, MX, MN, 1, 2, 3, HX, 5, HX, 64'h7FFF_7FFF_7FFF_7FFF),
                0, none);
        add_row(make_word(MX, MX, MN, MN, MX, 0, HX, HX, HX, 64'h8000_7FFF_8000_7FFF),
                0, none);
        add_row(make_word(MX, MN, MX, 0, 0, 0, 65536, 65536, 65536,
                          {16'h2D41, 16'h0, 16'h0, 16'h2D41}), 0, none);
        add_row(make_word(MN, MX, MN, 0, 0, 0, 65536, 131072, 65536,
                          {16'h2D41, 16'h2D41, 16'h0, 16'h0}), 0, none);
        add_row(make_word(-1, -1, -1, -1, -1, -1, HX, HX, HX, 64'hFFFF_FFFF_FFFF_FFFF),
                0, none);
        add_row(make_word(MX, MX, MX, 0, 0, 0, 1000, 2000, 3000,
                          {16'h2000, 16'h2000, 16'h2000, 16'h2000}), 0, none);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[n]) send_word(rows[n].w, rows[n].has_exp, rows[n].e);

        for (int n = 0; n < N_RANDOM; n++) begin
            send_word(rand_word(), 0, none);
            // sender hold-off until the pipeline drains
            if (n == N_RANDOM / 2) begin
                idle_input();
                while (near_q.size() != 0) @(posedge i_clk);
            end
        end

        idle_input();
        while (near_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
